// ===== hw/rtl/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3 package
// shared types and constants of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;
  localparam logic [31:0] PadWord = 32'h80000000;

  localparam logic [255:0] Iv = {32'h7380166F, 32'h4914B2B9, 32'h172442D7,
                                 32'hDA8A0600, 32'hA96F30BC, 32'h163138AA,
                                 32'hE38DEE4D, 32'hB0FB0E4E};

  // queue entry between front and back
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;   // word completes a block
    logic        msg_end;   // block ends the message
  } sm3_word_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== hw/rtl/sm3_front.sv =====
// ----------------------------------------------------------------------------
// sm3 front
// takes message words, adds padding and length, tags block and message ends
// ----------------------------------------------------------------------------
module sm3_front import sm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  word_bytes_i,
  input  logic        last_word_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output sm3_word_t   q_data_o
);

  localparam logic [1:0] StIn   = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;
  localparam logic [1:0] StLenH = 2'd2;
  localparam logic [1:0] StLenL = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [3:0]  fill_q, fill_d;
  logic [60:0] count_q, count_d;
  logic        pad80_q, pad80_d;   // 0x80 word still owed
  logic [63:0] bits;
  logic [2:0]  nb;
  logic [31:0] keep, mword;
  logic        push;
  sm3_word_t   w;

  assign bits = {count_q, 3'b000};
  assign nb = (!last_word_i || word_bytes_i > 3'd4) ? 3'd4 : word_bytes_i;

  always_comb begin
    case (nb)
      3'd0: keep = 32'h00000000;
      3'd1: keep = 32'hFF000000;
      3'd2: keep = 32'hFFFF0000;
      3'd3: keep = 32'hFFFFFF00;
      default: keep = 32'hFFFFFFFF;
    endcase
    mword = (data_word_i & keep);
    if (last_word_i && nb != 3'd4) mword = mword | (PadWord >> {nb, 3'b000});
  end

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    count_d = count_q;
    pad80_d = pad80_q;
    ready_o = 1'b0;
    push    = 1'b0;
    w.word  = mword;
    w.blk_end = (fill_q == 4'd15);
    w.msg_end = 1'b0;
    case (state_q)
      StIn: begin
        ready_o = q_ready_i;
        push = valid_i;
        if (valid_i && q_ready_i) begin
          fill_d = fill_q + 4'd1;
          if (last_word_i) begin
            count_d = count_q + 61'(nb);
            pad80_d = (nb == 3'd4);
            state_d = StPad;
          end else begin
            count_d = count_q + 61'd4;
          end
        end
      end
      StPad: begin
        push = 1'b1;
        w.word = pad80_q ? PadWord : 32'd0;
        if (fill_q == 4'd14 && !pad80_q) begin
          push = 1'b0;
          state_d = StLenH;
        end else if (q_ready_i) begin
          fill_d = fill_q + 4'd1;
          pad80_d = 1'b0;
        end
      end
      StLenH: begin
        push = 1'b1;
        w.word = bits[63:32];
        if (q_ready_i) begin
          fill_d = fill_q + 4'd1;
          state_d = StLenL;
        end
      end
      default: begin
        push = 1'b1;
        w.word = bits[31:0];
        w.msg_end = 1'b1;
        if (q_ready_i) begin
          fill_d  = 4'd0;
          count_d = '0;
          state_d = StIn;
        end
      end
    endcase
  end

  assign q_valid_o = push;
  assign q_data_o  = w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIn;
      fill_q  <= '0;
      count_q <= '0;
      pad80_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      pad80_q <= pad80_d;
    end
  end

endmodule

// ===== hw/rtl/sm3_queue.sv =====
// ----------------------------------------------------------------------------
// sm3 queue
// two-entry fifo between front and back
// ----------------------------------------------------------------------------
module sm3_queue import sm3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sm3_word_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sm3_word_t out_data_o
);

  sm3_word_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== hw/rtl/sm3_back.sv =====
// ----------------------------------------------------------------------------
// sm3 back
// block buffer, message expansion window and one compression round per cycle
// ----------------------------------------------------------------------------
module sm3_back import sm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  sm3_word_t   q_data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]  state_q;
  logic [31:0] win_q [16];   // w[j..j+15] sliding window
  logic [3:0]  ld_q;
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        fin_q;
  logic [255:0] cv_q, wk_q, nxt;
  logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj, wnew;

  assign q_ready_o = (state_q == StLoad);
  assign valid_o = (state_q == StOut);
  assign digest_word_o = cv_q[255 - {oidx_q, 5'd0} -: 32];
  assign digest_last_o = (oidx_q == 3'd7);

  always_comb begin
    {a, b, c, d, e, f, g, h} = wk_q;
    tj  = (rnd_q < 6'd16) ? TLow : THigh;
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + rotl(tj, rnd_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_q < 6'd16) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
    tt1 = ff + d + ss2 + (win_q[0] ^ win_q[4]);
    tt2 = gg + h + ss1 + win_q[0];
    nxt = {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};
    wnew = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15))
         ^ rotl(win_q[3], 5'd7) ^ win_q[10];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StLoad && q_valid_i) win_q[ld_q] <= q_data_i.word;
    if (state_q == StRun) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= wnew;
      wk_q <= nxt;
    end
    if (state_q == StLoad && q_valid_i && q_data_i.blk_end) wk_q <= cv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      ld_q <= '0;
      rnd_q <= '0;
      oidx_q <= '0;
      fin_q <= 1'b0;
      cv_q <= Iv;
    end else begin
      case (state_q)
        StLoad: if (q_valid_i) begin
          ld_q <= ld_q + 4'd1;
          if (q_data_i.blk_end) begin
            fin_q <= q_data_i.msg_end;
            rnd_q <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            cv_q <= cv_q ^ nxt;
            state_q <= fin_q ? StOut : StLoad;
          end
        end
        StOut: if (ready_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            cv_q <= Iv;
            state_q <= StLoad;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sm3_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sm3 hash engine
// compression: a block starts compressing once its sixteenth word is loaded
// input: words of the next block are held back while the round unit compresses a block
// digest: eight words after the final block, one per accepted output transaction
// reset: chaining value returns to the iv, counters clear; no clearing pass
// ----------------------------------------------------------------------------
module sm3_hash_engine import sm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  word_bytes_i,
  input  logic        last_word_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  sm3_word_t fq_data, qb_data;

  sm3_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .data_word_i, .word_bytes_i, .last_word_i,
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_data_o(fq_data)
  );

  sm3_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fq_valid), .in_ready_o(fq_ready), .in_data_i(fq_data),
    .out_valid_o(qb_valid), .out_ready_i(qb_ready), .out_data_o(qb_data)
  );

  sm3_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qb_valid), .q_ready_o(qb_ready), .q_data_i(qb_data),
    .valid_o, .ready_i, .digest_word_o, .digest_last_o
  );

endmodule
